// ----- design/cms_pkg.sv -----
// Shared constants for the chunk markup stripper.
// Holds the markup character codes and the mode codes; no dependencies.
`default_nettype none

package cms_pkg;

    // Byte values that steer the markup decoder.
    localparam logic [7:0] CH_ESC    = 8'h5C;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // Decoder mode vector and its codes.
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_NORMAL  = 3'd0;
    localparam mode_t MODE_BRACKET = 3'd1;
    localparam mode_t MODE_SKIP_SL = 3'd2;
    localparam mode_t MODE_BODY    = 3'd3;
    localparam mode_t MODE_SKIP_DL = 3'd4;

endpackage

`default_nettype wire

// ----- design/chunk_markup_stripper.sv -----
// Chunk markup stripper: top level, one byte in, zero or one byte out.
// Depends on cms_pkg for the character and mode codes.
//
// The block takes one text word per clock, save when throttled as described
// below, and removes chunk markup from the stream. Each accepted word lands in
// an input register; the mode decoder works on it there and, if the word is
// kept, loads it into the output register, which drives m_out_byte. A new
// word can be accepted every cycle; the only thing that throttles the input is
// a kept word that meets a full output register whose word has not yet been
// taken. Dropped words never touch the output register.
`default_nettype none

module chunk_markup_stripper (
    input  wire  logic       aclk,
    input  wire  logic       aresetn,
    input  wire  logic       s_valid,
    output logic             s_ready,
    input  wire  logic [7:0] s_in_byte,
    output logic             m_valid,
    input  wire  logic       m_ready,
    output logic [7:0]       m_out_byte
);
    import cms_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    mode_t      mode_reg;
    mode_t      mode_next;
    logic       esc_reg;
    logic       esc_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    mode_t      cur_mode;
    logic       copying;
    logic       emit;
    logic       advance;

    // Unused mode codes decode as normal mode.
    assign cur_mode = (mode_reg > MODE_SKIP_DL) ? MODE_NORMAL : mode_reg;
    assign copying  = (cur_mode == MODE_NORMAL) || (cur_mode == MODE_BRACKET) ||
                      (cur_mode == MODE_BODY);

    // Mode decoder for the word held in the input register.
    always_comb begin
        mode_next = cur_mode;
        esc_next  = esc_reg;
        emit      = 1'b0;
        if (esc_reg) begin
            esc_next = 1'b0;
            emit     = copying;
        end else if (in_byte_reg == CH_ESC) begin
            esc_next = 1'b1;
            emit     = copying;
        end else begin
            case (cur_mode)
                MODE_BRACKET: begin
                    emit = 1'b1;
                    if (in_byte_reg == CH_RBRK) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_SKIP_SL: begin
                    if (in_byte_reg == CH_SLASH) begin
                        mode_next = MODE_BODY;
                    end
                end
                MODE_BODY: begin
                    if (in_byte_reg == CH_RBRACE) begin
                        mode_next = MODE_SKIP_DL;
                    end else begin
                        emit = 1'b1;
                    end
                end
                MODE_SKIP_DL: begin
                    if (in_byte_reg == CH_DOLLAR) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                default: begin
                    if (in_byte_reg == CH_CARET) begin
                        mode_next = MODE_SKIP_SL;
                    end else begin
                        emit = 1'b1;
                        if (in_byte_reg == CH_LBRK) begin
                            mode_next = MODE_BRACKET;
                        end
                    end
                end
            endcase
        end
    end

    // The held word moves on unless it must be kept and the output is full and not being taken.
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // Decoder state, updated once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            esc_reg  <= 1'b0;
        end else if (advance) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            out_byte_reg <= in_byte_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;

endmodule

`default_nettype wire

// ----- design/cms_checker.sv -----
// Port-level checker for the chunk markup stripper, with its bind statement.
// Depends on the chunk_markup_stripper top level only.
`default_nettype none

module cms_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte
);

    // A stalled output word holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte))
    else $error("output word changed while stalled");

    // Reset empties the output.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
    else $error("output valid after reset");

    // A new output word must trace back to an accepted input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
    else $error("output word without matching input word");

    // With the output empty, the input is never throttled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
    else $error("input stalled while output is empty");

endmodule

bind chunk_markup_stripper cms_checker u_cms_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte)
);

`default_nettype wire
